/* rtl/swfr_pkg.sv */
// Shared types and constants of the stop-and-wait frame receiver.
package swfr_pkg;

	localparam int MAX_PAYLOAD_DEF = 1024;
	localparam int BODY_LIMIT_DEF  = 2070;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int COUNT_W         = 11;

	localparam logic [7:0] FLAG_BYTE = 8'h7E;
	localparam logic [7:0] ESC_BYTE  = 8'h7D;
	localparam logic [7:0] ESC_FLIP  = 8'h20;
	localparam logic [7:0] CTRL_I0   = 8'h00;
	localparam logic [7:0] CTRL_I1   = 8'h40;
	localparam logic [7:0] CTRL_DISC = 8'h0B;
	localparam logic [7:0] CTRL_RR   = 8'h05;
	localparam logic [7:0] CTRL_REJ  = 8'h01;
	localparam logic [7:0] SEQ_BIT   = 8'h80;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	typedef enum logic [2:0] {
		ST_ACCEPTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_DATA_ERR  = 3'd2,
		ST_HDR_ERR   = 3'd3,
		ST_SHORT     = 3'd4,
		ST_DISCONN   = 3'd5,
		ST_OTHER     = 3'd6,
		ST_OVERFLOW  = 3'd7
	} status_t;

	// One classified event handed from the deframer to the result stage.
	typedef struct packed {
		logic                 kind;
		logic [7:0]           data;
		status_t              status;
		logic [COUNT_W-1:0]   count;
		logic                 seq;
	} event_t;

endpackage

/* rtl/swfr_front.sv */
// Deframer: flag hunting, destuffing, header and payload checks, verdicts.
module swfr_front
	import swfr_pkg::*;
#(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
	parameter int BODY_LIMIT  = BODY_LIMIT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       byte_valid,
	input  logic [7:0] byte_in,
	output logic       ev_push,
	output event_t     ev
);

	localparam int MaxBody = MAX_PAYLOAD + 4;
	localparam int CntTop  = (BODY_LIMIT > MaxBody + 1) ? BODY_LIMIT : MaxBody + 1;
	localparam int CntW    = $clog2(CntTop + 1);
	localparam logic [CntW-1:0] BodyLim = CntW'(BODY_LIMIT);
	localparam logic [CntW-1:0] BodyMax = CntW'(MaxBody);
	localparam logic [CntW-1:0] Three   = CntW'(3);
	localparam logic [CntW-1:0] Four    = CntW'(4);

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_OPEN,
		PH_BODY
	} phase_t;

	phase_t          phase_q, phase_n;
	logic            link_open_q;
	logic            esc_q, esc_n;
	logic [CntW-1:0] bc_q, bc_n;
	logic [7:0]      addr_q, addr_n;
	logic [7:0]      ctrl_q, ctrl_n;
	logic [7:0]      bcc1_q, bcc1_n;
	logic [7:0]      held_q, held_n;
	logic [7:0]      pxor_q, pxor_n;
	logic            seq_q, seq_n;

	always_comb begin
		logic            do_store;
		logic            do_clear;
		logic [7:0]      v;
		logic            good;
		logic            emit;
		logic [CntW-1:0] sent;
		logic [CntW-1:0] nbc;
		logic [7:0]      prev;
		logic            is_i;
		do_store = 1'b0;
		do_clear = 1'b0;
		v        = byte_in;
		good     = 1'b0;
		emit     = 1'b0;
		sent     = '0;
		nbc      = '0;
		prev     = '0;
		is_i     = 1'b0;
		phase_n  = phase_q;
		esc_n    = esc_q;
		bc_n     = bc_q;
		addr_n   = addr_q;
		ctrl_n   = ctrl_q;
		bcc1_n   = bcc1_q;
		held_n   = held_q;
		pxor_n   = pxor_q;
		seq_n    = seq_q;
		ev_push  = 1'b0;
		ev       = '0;

		if (byte_valid && link_open_q) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (byte_in == FLAG_BYTE) begin
						do_clear = 1'b1;
						phase_n  = PH_OPEN;
					end
				end
				PH_OPEN: begin
					if (byte_in == ESC_BYTE) begin
						do_clear = 1'b1;
						phase_n  = PH_HUNT;
					end else if (byte_in != FLAG_BYTE) begin
						do_clear = 1'b1;
						do_store = 1'b1;
						phase_n  = PH_BODY;
					end
				end
				PH_BODY: begin
					if (esc_q) begin
						esc_n    = 1'b0;
						do_store = 1'b1;
						v        = byte_in ^ ESC_FLIP;
					end else if (byte_in == ESC_BYTE) begin
						esc_n = 1'b1;
					end else if (byte_in == FLAG_BYTE) begin
						// Closing flag: rank the frame and give one verdict.
						is_i      = (ctrl_q == CTRL_I0) || (ctrl_q == CTRL_I1);
						ev_push   = 1'b1;
						ev.kind   = KIND_VERDICT;
						ev.seq    = seq_q;
						if (bc_q < Three) begin
							ev.status = ST_SHORT;
						end else if ((addr_q ^ ctrl_q) != bcc1_q) begin
							ev.status = ST_HDR_ERR;
						end else if (is_i) begin
							if (bc_q < Four) begin
								ev.status = ST_SHORT;
							end else begin
								ev.count = COUNT_W'(bc_q - Four);
								if (pxor_q != 8'h00) begin
									ev.status = ST_DATA_ERR;
								end else if (ctrl_q[6] != seq_q) begin
									ev.status = ST_DUPLICATE;
								end else begin
									ev.status = ST_ACCEPTED;
									seq_n     = ~seq_q;
									ev.seq    = ~seq_q;
								end
							end
						end else if (ctrl_q == CTRL_DISC) begin
							ev.status = ST_DISCONN;
						end else begin
							ev.status = ST_OTHER;
						end
						do_clear = 1'b1;
						phase_n  = PH_OPEN;
					end else begin
						do_store = 1'b1;
					end
				end
				default: begin
					phase_n = PH_HUNT;
				end
			endcase
		end

		if (do_clear) begin
			esc_n  = 1'b0;
			bc_n   = '0;
			addr_n = '0;
			ctrl_n = '0;
			bcc1_n = '0;
			held_n = '0;
			pxor_n = '0;
		end

		if (do_store) begin
			prev = held_n;
			if (bc_n == CntW'(0)) begin
				addr_n = v;
			end else if (bc_n == CntW'(1)) begin
				ctrl_n = v;
			end else if (bc_n == CntW'(2)) begin
				bcc1_n = v;
			end else begin
				good = ((ctrl_n == CTRL_I0) || (ctrl_n == CTRL_I1)) &&
					((addr_n ^ ctrl_n) == bcc1_n);
				pxor_n = pxor_n ^ v;
				if (good && bc_n >= Four) begin
					emit = 1'b1;
					sent = bc_n - Four;
				end
				held_n = v;
			end
			nbc = bc_n + CntW'(1);
			if (nbc >= BodyLim || (good && nbc > BodyMax)) begin
				// Abort the frame; the count tells how many bytes already went out.
				ev_push   = 1'b1;
				ev.kind   = KIND_VERDICT;
				ev.status = ST_OVERFLOW;
				ev.count  = COUNT_W'(sent);
				esc_n     = 1'b0;
				bc_n      = '0;
				addr_n    = '0;
				ctrl_n    = '0;
				bcc1_n    = '0;
				held_n    = '0;
				pxor_n    = '0;
				phase_n   = PH_HUNT;
			end else begin
				bc_n = nbc;
				if (emit) begin
					ev_push = 1'b1;
					ev.kind = KIND_PAYLOAD;
					ev.data = prev;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			link_open_q <= 1'b0;
			esc_q       <= 1'b0;
			bc_q        <= '0;
			addr_q      <= '0;
			ctrl_q      <= '0;
			bcc1_q      <= '0;
			held_q      <= '0;
			pxor_q      <= '0;
			seq_q       <= 1'b0;
		end else if (cfg_we) begin
			link_open_q <= cfg_wdata;
			if (cfg_wdata && !link_open_q) begin
				// Opening the link restarts framing and the sequence bit.
				phase_q <= PH_HUNT;
				esc_q   <= 1'b0;
				bc_q    <= '0;
				addr_q  <= '0;
				ctrl_q  <= '0;
				bcc1_q  <= '0;
				held_q  <= '0;
				pxor_q  <= '0;
				seq_q   <= 1'b0;
			end
		end else begin
			phase_q <= phase_n;
			esc_q   <= esc_n;
			bc_q    <= bc_n;
			addr_q  <= addr_n;
			ctrl_q  <= ctrl_n;
			bcc1_q  <= bcc1_n;
			held_q  <= held_n;
			pxor_q  <= pxor_n;
			seq_q   <= seq_n;
		end
	end

	a_esc_in_body: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q |-> phase_q == PH_BODY)
		else $error("escape pending outside a frame body");

	a_count_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		bc_q < BodyLim)
		else $error("body count reached the limit without an abort");

endmodule

/* rtl/swfr_fifo.sv */
// Short event queue between the deframer and the result stage.
module swfr_fifo
	import swfr_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_en,
	input  event_t wr_data,
	input  logic   rd_en,
	output event_t rd_data,
	output logic   full,
	output logic   empty
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] DepthC  = CntW'(DEPTH);

	event_t          mem_q [DEPTH];
	logic [PtrW-1:0] wptr_q;
	logic [PtrW-1:0] rptr_q;
	logic [CntW-1:0] cnt_q;
	logic            do_wr;
	logic            do_rd;

	assign full    = (cnt_q == DepthC);
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CntW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DepthC)
		else $error("queue count above depth");

endmodule

/* rtl/swfr_back.sv */
// Result stage: formats queued events into the registered result beat.
module swfr_back
	import swfr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_empty,
	input  event_t       q_data,
	output logic         q_pop,
	input  logic         pop,
	output logic         empty,
	output logic         item_kind,
	output logic [7:0]   payload_byte,
	output logic [2:0]   frame_status,
	output logic [10:0]  payload_count,
	output logic         respond,
	output logic [7:0]   response_control
);

	logic         valid_q;
	logic         kind_q;
	logic [7:0]   byte_q;
	logic [2:0]   status_q;
	logic [10:0]  count_q;
	logic         resp_q;
	logic [7:0]   rctl_q;
	logic         take;
	logic         resp_n;
	logic [7:0]   rctl_n;

	assign take  = !valid_q || pop;
	assign q_pop = take && !q_empty;

	// Reply control byte follows from the verdict and the sequence bit.
	always_comb begin
		resp_n = 1'b0;
		rctl_n = '0;
		if (q_data.kind == KIND_VERDICT) begin
			unique case (q_data.status)
				ST_ACCEPTED, ST_DUPLICATE: begin
					resp_n = 1'b1;
					rctl_n = CTRL_RR | (q_data.seq ? SEQ_BIT : 8'h00);
				end
				ST_DATA_ERR: begin
					resp_n = 1'b1;
					rctl_n = CTRL_REJ | (q_data.seq ? SEQ_BIT : 8'h00);
				end
				ST_DISCONN: begin
					resp_n = 1'b1;
					rctl_n = CTRL_DISC;
				end
				default: begin
					resp_n = 1'b0;
					rctl_n = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind_q   <= q_data.kind;
			byte_q   <= (q_data.kind == KIND_PAYLOAD) ? q_data.data : 8'h00;
			status_q <= (q_data.kind == KIND_VERDICT) ? q_data.status : ST_ACCEPTED;
			count_q  <= (q_data.kind == KIND_VERDICT) ? q_data.count : '0;
			resp_q   <= resp_n;
			rctl_q   <= rctl_n;
		end
	end

	assign empty            = !valid_q;
	assign item_kind        = kind_q;
	assign payload_byte     = byte_q;
	assign frame_status     = status_q;
	assign payload_count    = count_q;
	assign respond          = resp_q;
	assign response_control = rctl_q;

	a_payload_no_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && kind_q == KIND_PAYLOAD) |-> (!resp_q && count_q == '0))
		else $error("payload beat carries verdict fields");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !pop) |=> (valid_q && $stable(rctl_q) && $stable(byte_q)))
		else $error("result beat changed while stalled");

endmodule

/* rtl/stop_and_wait_frame_receiver.sv */
// Top level of the stop-and-wait frame receiver.
//
// Input channel: line bytes are offered with push; a beat is taken at a rising
// edge with push high and full low. Bytes taken while link_open is clear are
// dropped without effect. Writing link_open from zero to one restarts framing
// and clears the expected sequence bit; the user must write link_open only
// while idle, which the block does not enforce.
// Result channel: while empty is low the oldest result beat is on the result
// ports, and pop at a rising edge with empty low takes it. A beat is either a
// tentative payload byte (item_kind 0), sent one body byte late because the
// last body byte is the payload check, or a frame verdict (item_kind 1) with
// status, payload count and the reply control byte when a reply is needed.
// The deframer decides in the cycle the byte is taken, the event queue holds
// the event at that edge, and the free output register then loads it onto the
// result ports, where pop can take it.
// Throughput is one line byte per cycle while full is low; the queue of
// QUEUE_DEPTH events lets the output stall without stopping input until the
// queue and the output register are full.
// Reset clears the link (closed), framing state and the sequence bit.
module stop_and_wait_frame_receiver
	import swfr_pkg::*;
#(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
	parameter int BODY_LIMIT  = BODY_LIMIT_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        link_open_we,
	input  logic        link_open_wdata,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  line_byte,
	output logic        empty,
	input  logic        pop,
	output logic        item_kind,
	output logic [7:0]  payload_byte,
	output logic [2:0]  frame_status,
	output logic [10:0] payload_count,
	output logic        respond,
	output logic [7:0]  response_control
);

	logic   byte_acc;
	logic   ev_push;
	event_t ev;
	logic   q_full;
	logic   q_empty;
	logic   q_pop;
	event_t q_data;

	// The queue takes every event the deframer produces, so input waits on it.
	assign full     = q_full;
	assign byte_acc = push && !q_full;

	swfr_front #(
		.MAX_PAYLOAD (MAX_PAYLOAD),
		.BODY_LIMIT  (BODY_LIMIT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (link_open_we),
		.cfg_wdata  (link_open_wdata),
		.byte_valid (byte_acc),
		.byte_in    (line_byte),
		.ev_push    (ev_push),
		.ev         (ev)
	);

	swfr_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (ev_push),
		.wr_data (ev),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.full    (q_full),
		.empty   (q_empty)
	);

	swfr_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_empty          (q_empty),
		.q_data           (q_data),
		.q_pop            (q_pop),
		.pop              (pop),
		.empty            (empty),
		.item_kind        (item_kind),
		.payload_byte     (payload_byte),
		.frame_status     (frame_status),
		.payload_count    (payload_count),
		.respond          (respond),
		.response_control (response_control)
	);

endmodule
